[sv/pfa_pkg.sv]
// Shared types, codes and defaults of the page-frame allocator.
package pfa_pkg;

	// Default sizing
	localparam int PAGE_COUNT_DEF = 65536;
	localparam int COUNT_BITS_DEF = 8;

	// Fixed field widths
	localparam int PAGE_W   = 16;
	localparam int STATUS_W = 3;
	localparam int REFCNT_W = 8;
	localparam int FREE_W   = 17;
	localparam int CFG_W    = 17;
	localparam int TDATA_W  = 48;

	// Register file indexes
	localparam logic REG_LOWEST_PAGE = 1'b0;
	localparam logic REG_PAGE_LIMIT  = 1'b1;

	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_INC   = 2'd2,
		KIND_DEC   = 2'd3
	} pfa_kind_t;

	typedef enum logic [2:0] {
		STAT_OK    = 3'd0,
		STAT_EMPTY = 3'd1,
		STAT_RANGE = 3'd2,
		STAT_FULL  = 3'd3,
		STAT_SAT   = 3'd4
	} pfa_status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} pfa_state_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;   // zero one count entry, advance sweep
		logic accept;  // latch request, launch memory reads
		logic commit;  // write memories, load output register
	} pfa_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last; // sweep is at the final entry
	} pfa_sts_t;

endpackage

[sv/pfa_ctrl.sv]
// Sequencing state machine of the page-frame allocator.
module pfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output pfa_pkg::pfa_cmd_t cmd,
	input  pfa_pkg::pfa_sts_t sts
);

	pfa_pkg::pfa_state_t state_q, state_d;
	logic out_valid_q;

	// State register and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfa_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			pfa_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = pfa_pkg::ST_IDLE;
				end
			end
			pfa_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = pfa_pkg::ST_EXEC;
				end
			end
			pfa_pkg::ST_EXEC: begin
				// wait here while the previous result is still unclaimed
				if (!out_valid_q || m_axis_tready) begin
					cmd.commit = 1'b1;
					state_d    = pfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfa_pkg::ST_IDLE;
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;

	// Every accepted request is executed in the following cycle or later
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == pfa_pkg::ST_EXEC)
		else $error("accept not followed by execute");

	// A commit never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || m_axis_tready))
		else $error("result overwritten");

	// A commit always presents a result next cycle
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_axis_tvalid)
		else $error("commit lost");

	// No request is taken before the count sweep has finished
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfa_pkg::ST_CLEAR |-> !s_axis_tready)
		else $error("request taken during clear");

endmodule

[sv/pfa_datapath.sv]
// Count memory, free-page stack, configuration and result registers.
module pfa_datapath #(
	parameter int PAGE_COUNT = pfa_pkg::PAGE_COUNT_DEF,
	parameter int COUNT_BITS = pfa_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfa_pkg::pfa_cmd_t             cmd,
	output pfa_pkg::pfa_sts_t             sts,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [pfa_pkg::CFG_W-1:0]     cfg_data,
	input  logic [1:0]                    in_kind,
	input  logic [pfa_pkg::PAGE_W-1:0]    in_page,
	output logic [pfa_pkg::TDATA_W-1:0]   out_data
);

	localparam int AW = $clog2(PAGE_COUNT);
	localparam int DW = $clog2(PAGE_COUNT + 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [AW-1:0] LAST_ADDR = AW'(PAGE_COUNT - 1);

	// Memories
	logic [COUNT_BITS-1:0]       cnt_mem [PAGE_COUNT];
	logic [pfa_pkg::PAGE_W-1:0]  stk_mem [PAGE_COUNT];

	// Registers
	logic [pfa_pkg::PAGE_W-1:0]  lowest_q;
	logic [pfa_pkg::CFG_W-1:0]   limit_q;
	logic [DW-1:0]               depth_q;
	logic [AW-1:0]               clr_addr_q;
	pfa_pkg::pfa_kind_t          kind_q;
	logic [pfa_pkg::PAGE_W-1:0]  page_q;
	logic [COUNT_BITS-1:0]       cnt_rd_q;
	logic [pfa_pkg::PAGE_W-1:0]  top_rd_q;
	pfa_pkg::pfa_status_t        stat_q;
	logic [pfa_pkg::PAGE_W-1:0]  rpage_q;
	logic [pfa_pkg::REFCNT_W-1:0] rcnt_q;
	logic [pfa_pkg::FREE_W-1:0]  free_q;

	// Execute-cycle results
	pfa_pkg::pfa_status_t        stat_x;
	logic [pfa_pkg::PAGE_W-1:0]  rpage_x;
	logic [COUNT_BITS-1:0]       rcnt_x;
	logic [DW-1:0]               depth_x;
	logic                        cnt_upd_x;
	logic [AW-1:0]               cnt_addr_x;
	logic [COUNT_BITS-1:0]       cnt_val_x;
	logic                        push_x;
	logic                        page_ok;
	logic [COUNT_BITS-1:0]       cnt_cur;
	logic [COUNT_BITS-1:0]       cnt_dec;

	// Count memory write port, shared by the clear sweep
	logic                        cnt_we;
	logic [AW-1:0]               cnt_waddr;
	logic [COUNT_BITS-1:0]       cnt_wdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q <= '0;
			limit_q  <= pfa_pkg::CFG_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				pfa_pkg::REG_LOWEST_PAGE: lowest_q <= cfg_data[pfa_pkg::PAGE_W-1:0];
				pfa_pkg::REG_PAGE_LIMIT:  limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stack depth and clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.commit) begin
				depth_q <= depth_x;
			end
			if (cmd.clear) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	assign sts.clear_last = (clr_addr_q == LAST_ADDR);

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= pfa_pkg::pfa_kind_t'(in_kind);
			page_q <= in_page;
		end
	end

	// Count memory: one write, one registered read at request time
	assign cnt_we    = cmd.clear || (cmd.commit && cnt_upd_x);
	assign cnt_waddr = cmd.clear ? clr_addr_q : cnt_addr_x;
	assign cnt_wdata = cmd.clear ? '0 : cnt_val_x;

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cmd.accept) begin
			cnt_rd_q <= cnt_mem[AW'(in_page)];
		end
	end

	// Free stack: push at depth, top read at depth - 1
	always_ff @(posedge clk) begin
		if (cmd.commit && push_x) begin
			stk_mem[AW'(depth_q)] <= page_q;
		end
		if (cmd.accept) begin
			top_rd_q <= stk_mem[AW'(depth_q - 1'b1)];
		end
	end

	// Operation decode and update
	assign page_ok = 32'(page_q) < 32'(PAGE_COUNT);
	assign cnt_cur = page_ok ? cnt_rd_q : '0;
	assign cnt_dec = (cnt_cur != '0) ? cnt_cur - 1'b1 : '0;

	always_comb begin
		stat_x     = pfa_pkg::STAT_OK;
		rpage_x    = page_q;
		rcnt_x     = cnt_cur;
		depth_x    = depth_q;
		cnt_upd_x  = 1'b0;
		cnt_addr_x = AW'(page_q);
		cnt_val_x  = cnt_cur;
		push_x     = 1'b0;
		case (kind_q)
			pfa_pkg::KIND_ALLOC: begin
				if (depth_q == '0) begin
					stat_x  = pfa_pkg::STAT_EMPTY;
					rpage_x = '0;
					rcnt_x  = '0;
				end else begin
					depth_x    = depth_q - 1'b1;
					rpage_x    = top_rd_q;
					rcnt_x     = COUNT_BITS'(1);
					cnt_upd_x  = 32'(top_rd_q) < 32'(PAGE_COUNT);
					cnt_addr_x = AW'(top_rd_q);
					cnt_val_x  = COUNT_BITS'(1);
				end
			end
			pfa_pkg::KIND_FREE: begin
				if (!page_ok || page_q < lowest_q || {1'b0, page_q} >= limit_q) begin
					stat_x = pfa_pkg::STAT_RANGE;
				end else begin
					rcnt_x    = cnt_dec;
					cnt_upd_x = 1'b1;
					cnt_val_x = cnt_dec;
					if (cnt_dec == '0) begin
						if (depth_q == DW'(PAGE_COUNT)) begin
							stat_x = pfa_pkg::STAT_FULL;
						end else begin
							push_x  = 1'b1;
							depth_x = depth_q + 1'b1;
						end
					end
				end
			end
			pfa_pkg::KIND_INC: begin
				if (!page_ok) begin
					stat_x = pfa_pkg::STAT_RANGE;
				end else if (cnt_cur == COUNT_MAX) begin
					stat_x = pfa_pkg::STAT_SAT;
				end else begin
					rcnt_x    = cnt_cur + 1'b1;
					cnt_upd_x = 1'b1;
					cnt_val_x = cnt_cur + 1'b1;
				end
			end
			pfa_pkg::KIND_DEC: begin
				if (!page_ok) begin
					stat_x = pfa_pkg::STAT_RANGE;
				end else if (cnt_cur == '0) begin
					stat_x = pfa_pkg::STAT_SAT;
				end else begin
					rcnt_x    = cnt_dec;
					cnt_upd_x = 1'b1;
					cnt_val_x = cnt_dec;
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			stat_q  <= stat_x;
			rpage_q <= rpage_x;
			rcnt_q  <= pfa_pkg::REFCNT_W'(rcnt_x);
			free_q  <= pfa_pkg::FREE_W'(depth_x);
		end
	end

	assign out_data = {4'b0000, free_q, rcnt_q, rpage_q, stat_q};

	// The stack never holds more pages than exist
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(depth_q) <= 32'(PAGE_COUNT))
		else $error("stack depth beyond page count");

	// A push moves the depth up by exactly one
	a_depth_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && push_x) |=> depth_q == $past(depth_q) + 1'b1)
		else $error("push did not advance depth");

	// An alloc on a non-empty stack moves the depth down by exactly one
	a_depth_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && kind_q == pfa_pkg::KIND_ALLOC && depth_q != '0)
		|=> depth_q == $past(depth_q) - 1'b1)
		else $error("pop did not lower depth");

endmodule

[sv/page_frame_allocator_refcount_unit.sv]
// Top level of the page-frame allocator with reference counts.
//
// Requests arrive on the s_axis channel: tuser carries the kind (alloc,
// free, increment, decrement) and tdata the page number. Each request
// yields exactly one result on the m_axis channel: status, result page,
// reference count and the number of free pages after the request.
// The user writes the configuration (lowest freeable page, exclusive page
// limit) via cfg_we / cfg_index / cfg_data while no request is in flight.
//
// In the accept cycle a request launches the reads of the count memory and
// of the top of the free stack; the execute state then updates both
// memories and loads the result register. A new request is taken only
// after that read-then-write, so no read sees a stale entry. The result
// is visible in the cycle after the update.
//
// After reset the count memory is swept to zero, one entry per cycle, over
// all PAGE_COUNT entries; tready stays low meanwhile. Configuration writes
// are taken during the sweep; the block does not enforce the in-flight rule
// for them. If the receiver stalls, the result register holds, and a
// following request waits in its update cycle until the result is taken.
module page_frame_allocator_refcount_unit #(
	parameter int PAGE_COUNT = pfa_pkg::PAGE_COUNT_DEF,
	parameter int COUNT_BITS = pfa_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [15:0]                 s_axis_tdata,  // [15:0] page
	input  logic [1:0]                  s_axis_tuser,  // [1:0] kind
	// result channel
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [2:0] status, [18:3] result_page, [26:19] ref_count,
	// [43:27] free_pages, [47:44] zero
	output logic [pfa_pkg::TDATA_W-1:0] m_axis_tdata,
	// configuration
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [pfa_pkg::CFG_W-1:0]   cfg_data
);

	pfa_pkg::pfa_cmd_t cmd;
	pfa_pkg::pfa_sts_t sts;

	pfa_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cmd           (cmd),
		.sts           (sts)
	);

	pfa_datapath #(
		.PAGE_COUNT (PAGE_COUNT),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_kind   (s_axis_tuser),
		.in_page   (s_axis_tdata),
		.out_data  (m_axis_tdata)
	);

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the page-frame allocator with reference counts.
`timescale 1ns / 100ps

module tb_top;

	localparam int         PAGES        = pfa_pkg::PAGE_COUNT_DEF;
	localparam logic [7:0] COUNT_TOP    = 8'hFF;
	localparam int         CYCLE_LIMIT  = 3_000_000;
	localparam int         SETTLE       = 4;
	localparam int         RANDOM_ITEMS = 300;

	typedef struct packed {
		logic [16:0]          free_cnt;
		logic [7:0]           count;
		logic [15:0]          page;
		pfa_pkg::pfa_status_t status;
	} alloc_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        s_axis_tvalid;
	logic                        s_axis_tready;
	logic [15:0]                 s_axis_tdata;   // [15:0] page
	logic [1:0]                  s_axis_tuser;   // [1:0] kind
	logic                        m_axis_tvalid;
	logic                        m_axis_tready;
	// [2:0] status, [18:3] result_page, [26:19] ref_count, [43:27] free_pages
	logic [pfa_pkg::TDATA_W-1:0] m_axis_tdata;
	logic                        cfg_we;
	logic                        cfg_index;
	logic [pfa_pkg::CFG_W-1:0]   cfg_data;

	// Allocator shadow state
	logic [7:0]  cnt_mem [PAGES];
	logic [15:0] stk_mem [PAGES];
	int          stk_depth;
	logic [15:0] win_low;
	logic [16:0] win_limit;

	alloc_result_t pending_results [$];
	bit            feed_idle;
	bit            sink_idle;
	int            requests_sent = 0;
	int            results_seen  = 0;
	int            mismatches    = 0;
	int            cycle_count   = 0;
	int            status_seen [5] = '{default: 0};

	page_frame_allocator_refcount_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Shadow allocator: one request in, the result it must produce out
	function automatic void alloc_predict(input pfa_pkg::pfa_kind_t kind,
			input logic [15:0] pg, output alloc_result_t res);
		logic [7:0] cnt;
		cnt        = cnt_mem[pg];
		res.status = pfa_pkg::STAT_OK;
		res.page   = pg;
		res.count  = cnt;
		case (kind)
			pfa_pkg::KIND_ALLOC: begin
				if (stk_depth == 0) begin
					res.status = pfa_pkg::STAT_EMPTY;
					res.page   = '0;
					res.count  = '0;
				end else begin
					stk_depth--;
					res.page          = stk_mem[stk_depth];
					cnt_mem[res.page] = 8'd1;
					res.count         = 8'd1;
				end
			end
			pfa_pkg::KIND_FREE: begin
				if (pg < win_low || {1'b0, pg} >= win_limit) begin
					res.status = pfa_pkg::STAT_RANGE;
				end else begin
					if (cnt != 0)
						cnt--;
					cnt_mem[pg] = cnt;
					res.count   = cnt;
					// a page reaching zero goes back on the stack, if there is room
					if (cnt == 0) begin
						if (stk_depth >= PAGES) begin
							res.status = pfa_pkg::STAT_FULL;
						end else begin
							stk_mem[stk_depth] = pg;
							stk_depth++;
						end
					end
				end
			end
			pfa_pkg::KIND_INC: begin
				if (cnt == COUNT_TOP) begin
					res.status = pfa_pkg::STAT_SAT;
				end else begin
					cnt_mem[pg] = cnt + 8'd1;
					res.count   = cnt + 8'd1;
				end
			end
			default: begin
				if (cnt == 0) begin
					res.status = pfa_pkg::STAT_SAT;
				end else begin
					cnt_mem[pg] = cnt - 8'd1;
					res.count   = cnt - 8'd1;
				end
			end
		endcase
		res.free_cnt = stk_depth[16:0];
		status_seen[res.status]++;
	endfunction

	// Drive one request and book its expected result once accepted
	task automatic send_request(input pfa_pkg::pfa_kind_t kind, input logic [15:0] pg,
			output alloc_result_t res);
		int gap;
		gap = feed_idle ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = kind;
		s_axis_tdata  = pg;
		do @(posedge clk); while (!s_axis_tready);
		alloc_predict(kind, pg, res);
		pending_results.push_back(res);
		requests_sent++;
	endtask

	// Stop sending and let every outstanding result come back
	task automatic finish_burst;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [16:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == pfa_pkg::REG_LOWEST_PAGE)
			win_low = val[15:0];
		else
			win_limit = val;
	endtask

	task automatic set_window(input logic [15:0] lo, input logic [16:0] lim);
		finish_burst;
		write_cfg(pfa_pkg::REG_LOWEST_PAGE, {1'b0, lo});
		write_cfg(pfa_pkg::REG_PAGE_LIMIT, lim);
	endtask

	// Writes during the clearing sweep, then first requests on a closed window
	task automatic test_config_at_reset;
		alloc_result_t res;
		write_cfg(pfa_pkg::REG_LOWEST_PAGE, 17'h0FFFF);
		write_cfg(pfa_pkg::REG_PAGE_LIMIT, 17'h00000);
		send_request(pfa_pkg::KIND_FREE, 16'h0000, res);
		send_request(pfa_pkg::KIND_FREE, 16'hFFFF, res);
		send_request(pfa_pkg::KIND_ALLOC, 16'h0000, res);
		set_window(16'h0000, 17'h10000);
	endtask

	// Every kind, both ends of the page field, empty stack, repeat free
	task automatic test_directed_ops;
		alloc_result_t res;
		send_request(pfa_pkg::KIND_ALLOC, 16'h0000, res);
		send_request(pfa_pkg::KIND_DEC, 16'h0000, res);
		send_request(pfa_pkg::KIND_FREE, 16'hFFFF, res);
		send_request(pfa_pkg::KIND_FREE, 16'h0000, res);
		send_request(pfa_pkg::KIND_FREE, 16'h0000, res);
		send_request(pfa_pkg::KIND_INC, 16'hFFFF, res);
		repeat (4) send_request(pfa_pkg::KIND_ALLOC, 16'hFFFF, res);
		send_request(pfa_pkg::KIND_INC, 16'hA5C3, res);
		send_request(pfa_pkg::KIND_INC, 16'hA5C3, res);
		send_request(pfa_pkg::KIND_FREE, 16'hA5C3, res);
		send_request(pfa_pkg::KIND_FREE, 16'hA5C3, res);
		send_request(pfa_pkg::KIND_DEC, 16'hFFFF, res);
		send_request(pfa_pkg::KIND_DEC, 16'hFFFF, res);
		send_request(pfa_pkg::KIND_INC, 16'h0000, res);
		send_request(pfa_pkg::KIND_ALLOC, 16'h5A3C, res);
		finish_burst;
	endtask

	// Free window edges, single-page window, inverted and empty windows
	task automatic test_free_window;
		alloc_result_t res;
		set_window(16'h0100, 17'h00200);
		send_request(pfa_pkg::KIND_FREE, 16'h00FF, res);
		send_request(pfa_pkg::KIND_FREE, 16'h0100, res);
		send_request(pfa_pkg::KIND_FREE, 16'h01FF, res);
		send_request(pfa_pkg::KIND_FREE, 16'h0200, res);
		send_request(pfa_pkg::KIND_INC, 16'h00FF, res);
		send_request(pfa_pkg::KIND_DEC, 16'h00FF, res);
		set_window(16'hFFFF, 17'h10000);
		send_request(pfa_pkg::KIND_FREE, 16'hFFFF, res);
		send_request(pfa_pkg::KIND_FREE, 16'hFFFE, res);
		set_window(16'h8000, 17'h04000);
		send_request(pfa_pkg::KIND_FREE, 16'h6000, res);
		send_request(pfa_pkg::KIND_FREE, 16'h8000, res);
		set_window(16'h0000, 17'h00000);
		send_request(pfa_pkg::KIND_FREE, 16'h0000, res);
		set_window(16'h0000, 17'h10000);
	endtask

	// Run one count up to its ceiling, then take a neighbor below zero
	task automatic test_count_saturation;
		alloc_result_t res;
		logic [15:0]   pg;
		logic [15:0]   other;
		pg    = 16'($urandom);
		other = pg ^ 16'h0001;
		while (cnt_mem[pg] != COUNT_TOP)
			send_request(pfa_pkg::KIND_INC, pg, res);
		send_request(pfa_pkg::KIND_INC, pg, res);
		send_request(pfa_pkg::KIND_DEC, pg, res);
		send_request(pfa_pkg::KIND_FREE, pg, res);
		while (cnt_mem[other] != 0)
			send_request(pfa_pkg::KIND_DEC, other, res);
		send_request(pfa_pkg::KIND_DEC, other, res);
		finish_burst;
	endtask

	// Alloc/free/increment/decrement traffic on a small page pool, with noise and window edges
	task automatic test_random_traffic;
		alloc_result_t      res;
		logic [15:0]        held [$];
		logic [15:0]        pool_base;
		logic [15:0]        pg;
		logic [15:0]        lo;
		logic [16:0]        lim;
		pfa_pkg::pfa_kind_t kind;
		int                 r;
		int                 idx;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					lo  = 16'h0000;
					lim = 17'h10000;
				end
				1: begin
					lo  = 16'($urandom_range(0, 65000));
					lim = lo + 17'($urandom_range(1, 512));
				end
				2: begin
					lo  = 16'($urandom_range(1024, 65535));
					lim = 17'($urandom_range(0, lo));
				end
				default: begin
					lo  = 16'h0000;
					lim = 17'($urandom_range(1, 65536));
				end
			endcase
			set_window(lo, lim);
			feed_idle = (phase != 1) && (phase != 3);
			sink_idle = (phase != 2) && (phase != 3);
			if (lo < lim)
				pool_base = 16'($urandom_range(lo, lim - 1));
			else
				pool_base = 16'($urandom);
			repeat (RANDOM_ITEMS / 4) begin
				r    = $urandom_range(0, 99);
				kind = (r < 30) ? pfa_pkg::KIND_ALLOC : (r < 65) ? pfa_pkg::KIND_FREE :
					(r < 85) ? pfa_pkg::KIND_INC : pfa_pkg::KIND_DEC;
				r = $urandom_range(0, 99);
				// half of the frees return pages handed out earlier, while any are held
				if (kind == pfa_pkg::KIND_FREE && held.size() != 0 && r < 50) begin
					idx = $urandom_range(0, held.size() - 1);
					pg  = held[idx];
					held.delete(idx);
				end else if (r < 75) begin
					pg = pool_base + 16'($urandom_range(0, 15));
				end else if (r < 90) begin
					pg = 16'($urandom);
				end else begin
					case ($urandom_range(0, 3))
						0:       pg = lo;
						1:       pg = lo - 16'd1;
						2:       pg = lim[15:0];
						default: pg = lim[15:0] - 16'd1;
					endcase
				end
				send_request(kind, pg, res);
				if (kind == pfa_pkg::KIND_ALLOC && res.status == pfa_pkg::STAT_OK)
					held.push_back(res.page);
			end
		end
		feed_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	// Result sink with random backpressure
	initial begin : result_sink
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_idle ? $urandom_range(0, 3) : 0;
			repeat (stall) begin
				@(negedge clk);
				m_axis_tready = 1'b0;
			end
			@(negedge clk);
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Compare each returned result against the oldest booked one
	always @(posedge clk) begin : result_check
		alloc_result_t got;
		alloc_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.status   = pfa_pkg::pfa_status_t'(m_axis_tdata[2:0]);
			got.page     = m_axis_tdata[18:3];
			got.count    = m_axis_tdata[26:19];
			got.free_cnt = m_axis_tdata[43:27];
			results_seen++;
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("[%0t] result with no request outstanding: st=%0d pg=%h cnt=%0d",
						$time, got.status, got.page, got.count);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.page !== want.page ||
						got.count !== want.count || got.free_cnt !== want.free_cnt) begin
					if (mismatches < 10)
						$display({"[%0t] result %0d: want st=%0d pg=%h cnt=%0d free=%0d,",
							" got st=%0d pg=%h cnt=%0d free=%0d"}, $time, results_seen,
							want.status, want.page, want.count, want.free_cnt,
							got.status, got.page, got.count, got.free_cnt);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = pfa_pkg::KIND_ALLOC;
		cfg_we        = 1'b0;
		cfg_index     = pfa_pkg::REG_LOWEST_PAGE;
		cfg_data      = '0;
		feed_idle     = 1'b1;
		sink_idle     = 1'b1;
		stk_depth     = 0;
		win_low       = 16'h0000;
		win_limit     = 17'h10000;
		foreach (cnt_mem[i])
			cnt_mem[i] = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_config_at_reset;
		test_directed_ops;
		test_free_window;
		test_count_saturation;
		test_random_traffic;
		finish_burst;

		$display("Covered %0d requests, %0d results checked, %0d mismatching",
			requests_sent, results_seen, mismatches);
		$display("Status mix ok/empty/range/full/saturated: %0d/%0d/%0d/%0d/%0d",
			status_seen[pfa_pkg::STAT_OK], status_seen[pfa_pkg::STAT_EMPTY],
			status_seen[pfa_pkg::STAT_RANGE], status_seen[pfa_pkg::STAT_FULL],
			status_seen[pfa_pkg::STAT_SAT]);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
